### rtl/core/sexpr_pkg.sv
package sexpr_pkg;

    // Field widths
    localparam int OFFSET_BITS   = 24;
    localparam int POSITION_BITS = 16;
    localparam int KIND_BITS     = 3;

    // Token queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_SYMBOL = 2'd2
    } t_mode;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LPAREN = 3'd0,
        KIND_RPAREN = 3'd1,
        KIND_STRING = 3'd2,
        KIND_SYMBOL = 3'd3,
        KIND_END    = 3'd4,
        KIND_ERROR  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] column;
        logic [OFFSET_BITS-1:0]   offset;
        logic [OFFSET_BITS-1:0]   length;
        logic                     last;
    } t_token;

endpackage

### rtl/core/sexpr_token_scanner_core.sv
// S-expression token scanner. One source byte enters per accepted word on
// the input channel (byte 0 ends the text); tokens leave on the output channel
// with kind, start line, start column, value offset and value length, and
// last_of_run marks the final token that a byte caused (a byte causes zero,
// one, or two tokens). The block takes one byte per cycle unless stalled: a
// byte is held in the input register, where the scanner state machine
// handles it, and its tokens are written into a four-deep token queue that
// drives the output ports. Input is stalled only while the token queue holds
// more than two tokens, which happens when the output side stalls or bytes
// that cause two tokens (a symbol ended by a paren or end of text, or a
// string cut by end of text) arrive faster than tokens drain. Offset,
// line and column saturate at all ones; after end of text the scanner starts
// fresh.
module sexpr_token_scanner_core
    import sexpr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // byte input
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_text_byte,
    // token output
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [KIND_BITS-1:0]     o_token_kind,
    output logic [POSITION_BITS-1:0] o_start_line,
    output logic [POSITION_BITS-1:0] o_start_column,
    output logic [OFFSET_BITS-1:0]   o_value_offset,
    output logic [OFFSET_BITS-1:0]   o_value_length,
    output logic                     o_last_of_run
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        return (&v) ? v : v + OFFSET_BITS'(1);
    endfunction

    function automatic t_token make_token(
        input t_kind                    kind,
        input logic [POSITION_BITS-1:0] line,
        input logic [POSITION_BITS-1:0] column,
        input logic [OFFSET_BITS-1:0]   offset,
        input logic [OFFSET_BITS-1:0]   length,
        input logic                     last
    );
        t_token t;
        t.kind   = kind;
        t.line   = line;
        t.column = column;
        t.offset = offset;
        t.length = length;
        t.last   = last;
        return t;
    endfunction

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       proc;
    logic       room;

    // Scanner state
    t_mode                    r_mode,       n_mode;
    logic [OFFSET_BITS-1:0]   r_offset,     n_offset;
    logic [POSITION_BITS-1:0] r_line,       n_line;
    logic [POSITION_BITS-1:0] r_column,     n_column;
    logic [OFFSET_BITS-1:0]   r_tok_offset, n_tok_offset;
    logic [POSITION_BITS-1:0] r_tok_line,   n_tok_line;
    logic [POSITION_BITS-1:0] r_tok_column, n_tok_column;

    // Token queue
    t_token                r_queue [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPTR_BITS-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QCNT_BITS-1:0]  r_count,  n_count;
    logic                  pop;

    // Per-byte decode and results
    logic                     is_nul, is_space, is_paren, is_quote;
    logic [POSITION_BITS-1:0] step_line, step_column;
    logic [OFFSET_BITS-1:0]   step_offset;
    t_kind                    paren_kind;
    t_token                   tok0, tok1;
    logic [1:0]               num_tokens;

    // Take a new byte while the queue has room for two more tokens
    assign room    = r_count <= QCNT_BITS'(QUEUE_DEPTH - 2);
    assign proc    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_text_byte;
        end
    end

    // Classify the byte and form its position step
    always_comb begin
        is_nul      = r_in_byte == CHAR_NUL;
        is_space    = (r_in_byte == CHAR_SPACE) ||
                      ((r_in_byte >= CHAR_TAB) && (r_in_byte <= CHAR_CR));
        is_paren    = (r_in_byte == CHAR_LPAREN) || (r_in_byte == CHAR_RPAREN);
        is_quote    = r_in_byte == CHAR_QUOTE;
        paren_kind  = (r_in_byte == CHAR_LPAREN) ? KIND_LPAREN : KIND_RPAREN;
        step_line   = (r_in_byte == CHAR_LF) ? sat_pos(r_line) : r_line;
        step_column = (r_in_byte == CHAR_LF) ? POS_ONE : sat_pos(r_column);
        step_offset = sat_off(r_offset);
    end

    // Scanner next state and tokens
    always_comb begin
        n_mode       = r_mode;
        n_offset     = r_offset;
        n_line       = r_line;
        n_column     = r_column;
        n_tok_offset = r_tok_offset;
        n_tok_line   = r_tok_line;
        n_tok_column = r_tok_column;
        num_tokens   = 2'd0;
        tok0 = make_token(KIND_SYMBOL, r_tok_line, r_tok_column, r_tok_offset,
                          r_offset - r_tok_offset, 1'b1);
        tok1 = make_token(KIND_END, r_line, r_column, r_offset, '0, 1'b1);

        unique case (r_mode)
            MODE_STRING: begin
                if (is_nul) begin
                    tok0 = make_token(KIND_ERROR, r_tok_line, r_tok_column,
                                      r_tok_offset, '0, 1'b0);
                    num_tokens = 2'd2;
                end else if (is_quote) begin
                    tok0.kind  = KIND_STRING;
                    num_tokens = 2'd1;
                    n_mode     = MODE_IDLE;
                end
            end
            MODE_SYMBOL: begin
                if (is_space) begin
                    num_tokens = 2'd1;
                    n_mode     = MODE_IDLE;
                end else if (is_nul) begin
                    tok0.last  = 1'b0;
                    num_tokens = 2'd2;
                end else if (is_paren) begin
                    tok0.last  = 1'b0;
                    tok1.kind  = paren_kind;
                    num_tokens = 2'd2;
                    n_mode     = MODE_IDLE;
                end
            end
            default: begin
                if (is_nul) begin
                    tok0       = tok1;
                    num_tokens = 2'd1;
                end else if (is_paren) begin
                    tok0 = make_token(paren_kind, r_line, r_column, r_offset, '0, 1'b1);
                    num_tokens = 2'd1;
                    n_mode     = MODE_IDLE;
                end else if (is_quote) begin
                    n_tok_line   = r_line;
                    n_tok_column = r_column;
                    n_tok_offset = step_offset;
                    n_mode       = MODE_STRING;
                end else if (!is_space) begin
                    n_tok_line   = r_line;
                    n_tok_column = r_column;
                    n_tok_offset = r_offset;
                    n_mode       = MODE_SYMBOL;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
        endcase

        // Advance position on every byte but end of text, which restarts
        if (is_nul) begin
            n_mode       = MODE_IDLE;
            n_offset     = '0;
            n_line       = POS_ONE;
            n_column     = POS_ONE;
            n_tok_offset = '0;
            n_tok_line   = POS_ONE;
            n_tok_column = POS_ONE;
        end else begin
            n_offset = step_offset;
            n_line   = step_line;
            n_column = step_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_offset     <= '0;
            r_line       <= POS_ONE;
            r_column     <= POS_ONE;
            r_tok_offset <= '0;
            r_tok_line   <= POS_ONE;
            r_tok_column <= POS_ONE;
        end else if (proc) begin
            r_mode       <= n_mode;
            r_offset     <= n_offset;
            r_line       <= n_line;
            r_column     <= n_column;
            r_tok_offset <= n_tok_offset;
            r_tok_line   <= n_tok_line;
            r_tok_column <= n_tok_column;
        end
    end

    // Token queue pointers and fill count
    assign pop = o_valid && !i_stall;

    always_comb begin
        n_rd_ptr = pop ? r_rd_ptr + QPTR_BITS'(1) : r_rd_ptr;
        n_wr_ptr = proc ? r_wr_ptr + QPTR_BITS'(num_tokens) : r_wr_ptr;
        n_count  = r_count + (proc ? QCNT_BITS'(num_tokens) : '0)
                   - (pop ? QCNT_BITS'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    // Write up to two tokens per byte
    always_ff @(posedge i_clk) begin
        if (proc && (num_tokens != 2'd0)) begin
            r_queue[r_wr_ptr] <= tok0;
        end
        if (proc && (num_tokens == 2'd2)) begin
            r_queue[r_wr_ptr + QPTR_BITS'(1)] <= tok1;
        end
    end

    // Drive the head of the queue
    assign o_valid        = r_count != '0;
    assign o_token_kind   = r_queue[r_rd_ptr].kind;
    assign o_start_line   = r_queue[r_rd_ptr].line;
    assign o_start_column = r_queue[r_rd_ptr].column;
    assign o_value_offset = r_queue[r_rd_ptr].offset;
    assign o_value_length = r_queue[r_rd_ptr].length;
    assign o_last_of_run  = r_queue[r_rd_ptr].last;

    // Queue never overfills
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("token queue overfilled");

    // End of text restarts the position counters
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_in_byte == CHAR_NUL) |=>
            (r_offset == '0) && (r_line == POS_ONE) && (r_column == POS_ONE)
            && (r_mode == MODE_IDLE))
        else $error("scanner did not restart after end of text");

    // A byte inside a string adds no token
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && (r_mode == MODE_STRING) && (r_in_byte != CHAR_NUL)
            && (r_in_byte != CHAR_QUOTE) |=> r_count <= $past(r_count))
        else $error("string body produced a token");

    // Queue count tracks the pointers
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != QCNT_BITS'(QUEUE_DEPTH)) |->
            (r_wr_ptr - r_rd_ptr) == r_count[QPTR_BITS-1:0])
        else $error("token queue pointers out of step");

endmodule

### bench/tb_sexpr_token_scanner_core.sv
`timescale 1ns / 100ps

module tb_sexpr_token_scanner_core;
    import sexpr_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int RANDOM_BYTES  = 200;
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_style;

    typedef enum int {
        PIECE_LPAREN,
        PIECE_RPAREN,
        PIECE_STRING,
        PIECE_SYMBOL,
        PIECE_BLANK,
        PIECE_NOISE
    } t_piece;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [7:0]               i_text_byte = 8'h00;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [KIND_BITS-1:0]     o_token_kind;
    logic [POSITION_BITS-1:0] o_start_line;
    logic [POSITION_BITS-1:0] o_start_column;
    logic [OFFSET_BITS-1:0]   o_value_offset;
    logic [OFFSET_BITS-1:0]   o_value_length;
    logic                     o_last_of_run;

    sexpr_token_scanner_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_value_offset (o_value_offset),
        .o_value_length (o_value_length),
        .o_last_of_run  (o_last_of_run)
    );

    // scanner state as predicted
    t_mode                    cur_mode = MODE_IDLE;
    logic [OFFSET_BITS-1:0]   cur_offset = '0;
    logic [POSITION_BITS-1:0] cur_line = POS_ONE;
    logic [POSITION_BITS-1:0] cur_column = POS_ONE;
    logic [OFFSET_BITS-1:0]   tok_offset = '0;
    logic [POSITION_BITS-1:0] tok_line = POS_ONE;
    logic [POSITION_BITS-1:0] tok_column = POS_ONE;

    t_token       pending_tokens[$];
    int           mismatch_count = 0;
    int           bytes_sent = 0;
    int           burst_left = 0;
    bit           valid_held = 1'b0;
    int           cycle_count = 0;
    int           stall_left = 0;
    t_stall_style stall_style = STALL_NONE;

    initial forever #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void clear_scan_state();
        cur_mode   = MODE_IDLE;
        cur_offset = '0;
        cur_line   = POS_ONE;
        cur_column = POS_ONE;
        tok_offset = '0;
        tok_line   = POS_ONE;
        tok_column = POS_ONE;
    endfunction

    // advance offset, line and column past one byte, saturating
    function automatic void advance_position(input logic [7:0] c);
        if (c == CHAR_LF) begin
            if (!(&cur_line)) cur_line = cur_line + 1'b1;
            cur_column = POS_ONE;
        end else if (!(&cur_column)) begin
            cur_column = cur_column + 1'b1;
        end
        if (!(&cur_offset)) cur_offset = cur_offset + 1'b1;
    endfunction

    function automatic t_token make_token(input t_kind kind,
                                          input logic [POSITION_BITS-1:0] line,
                                          input logic [POSITION_BITS-1:0] column,
                                          input logic [OFFSET_BITS-1:0] offset,
                                          input logic [OFFSET_BITS-1:0] length);
        t_token t;
        t.kind   = kind;
        t.line   = line;
        t.column = column;
        t.offset = offset;
        t.length = length;
        t.last   = 1'b0;
        return t;
    endfunction

    // work out the tokens one byte causes and queue them
    function automatic void predict_tokens(input logic [7:0] c);
        t_token run[$];
        bit     done;
        bit     paren;
        done  = 1'b0;
        paren = (c == CHAR_LPAREN) || (c == CHAR_RPAREN);

        if (cur_mode == MODE_STRING) begin
            if (c == CHAR_NUL) begin
                run.push_back(make_token(KIND_ERROR, tok_line, tok_column, tok_offset, '0));
            end else if (c == CHAR_QUOTE) begin
                run.push_back(make_token(KIND_STRING, tok_line, tok_column, tok_offset,
                                         cur_offset - tok_offset));
                advance_position(c);
                cur_mode = MODE_IDLE;
                done = 1'b1;
            end else begin
                advance_position(c);
                done = 1'b1;
            end
        end else if (cur_mode == MODE_SYMBOL) begin
            if (c == CHAR_NUL || is_blank(c) || paren) begin
                run.push_back(make_token(KIND_SYMBOL, tok_line, tok_column, tok_offset,
                                         cur_offset - tok_offset));
                cur_mode = MODE_IDLE;
                if (is_blank(c)) begin
                    advance_position(c);
                    done = 1'b1;
                end
            end else begin
                advance_position(c);
                done = 1'b1;
            end
        end

        // between tokens, or right after a token this byte closed
        if (!done) begin
            if (run.size() == 0 && is_blank(c)) begin
                advance_position(c);
            end else if (c == CHAR_NUL) begin
                run.push_back(make_token(KIND_END, cur_line, cur_column, cur_offset, '0));
                clear_scan_state();
            end else if (paren) begin
                run.push_back(make_token((c == CHAR_LPAREN) ? KIND_LPAREN : KIND_RPAREN,
                                         cur_line, cur_column, cur_offset, '0));
                advance_position(c);
            end else if (c == CHAR_QUOTE) begin
                tok_line   = cur_line;
                tok_column = cur_column;
                advance_position(c);
                tok_offset = cur_offset;
                cur_mode   = MODE_STRING;
            end else begin
                tok_line   = cur_line;
                tok_column = cur_column;
                tok_offset = cur_offset;
                advance_position(c);
                cur_mode   = MODE_SYMBOL;
            end
        end

        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) pending_tokens.push_back(run[i]);
    endfunction

    // ---------------------------------------------------------------- byte sender

    // hold the word until accepted, then predict; idle between bursts
    task automatic send_byte(input logic [7:0] b);
        if (!valid_held) i_valid <= 1'b1;
        valid_held = 1'b1;
        i_text_byte <= b;
        do @(posedge i_clk); while (o_stall);
        predict_tokens(b);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 30);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // ---------------------------------------------------------------- token checker

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_tokens.size() == 0) begin
                $error("token kind %0d at line %0d column %0d with none expected",
                       o_token_kind, o_start_line, o_start_column);
                mismatch_count++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("token_kind", 32'(want.kind), 32'(o_token_kind));
                check_field("start_line", 32'(want.line), 32'(o_start_line));
                check_field("start_column", 32'(want.column), 32'(o_start_column));
                check_field("value_offset", 32'(want.offset), 32'(o_value_offset));
                check_field("value_length", 32'(want.length), 32'(o_value_length));
                check_field("last_of_run", 32'(want.last), 32'(o_last_of_run));
            end
        end
    end

    // receiver stall pattern: pick a random style for a random run length
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= t_stall_style'($urandom_range(0, 3));
            stall_left  <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
            default:        i_stall <= (stall_left % 5 < 2);
        endcase
    end

    // hang guard
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("sexpr_token_scanner_core: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_paren_string_symbol();
        send_text("(ab \"x y\")");
        send_byte(CHAR_NUL);
    endtask

    // symbols closed by parens, blank and end of text; quote inside symbol
    task automatic test_symbol_endings();
        send_text("a(b)q\"z\t\"\"c");
        send_byte(CHAR_NUL);
    endtask

    // lone end, unterminated string, every blank, byte extremes
    task automatic test_blanks_and_bad_strings();
        send_byte(CHAR_NUL);
        send_text("\"ab");
        send_byte(CHAR_NUL);
        send_text(" \t\v\f\r\n");
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(CHAR_QUOTE);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(CHAR_QUOTE);
        send_byte(CHAR_RPAREN);
        send_byte(CHAR_NUL);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_LF;
            3:       return CHAR_VT;
            4:       return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_symbol_byte(input bit first);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (is_blank(b) || b == CHAR_LPAREN || b == CHAR_RPAREN ||
               (first && b == CHAR_QUOTE));
        return b;
    endfunction

    function automatic logic [7:0] pick_string_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == CHAR_QUOTE);
        return b;
    endfunction

    function automatic int pick_length(input int lo, input int hi);
        return ($urandom_range(0, 15) == 0) ? $urandom_range(hi, 40) : $urandom_range(lo, hi);
    endfunction

    // one well-formed text with random content, mostly; some noise and cut strings
    task automatic send_random_text();
        t_piece kind;
        int     pick;
        int     len;
        repeat ($urandom_range(1, 10)) begin
            pick = $urandom_range(0, 15);
            if (pick < 2)       kind = PIECE_LPAREN;
            else if (pick < 4)  kind = PIECE_RPAREN;
            else if (pick < 7)  kind = PIECE_STRING;
            else if (pick < 11) kind = PIECE_SYMBOL;
            else if (pick < 15) kind = PIECE_BLANK;
            else                kind = PIECE_NOISE;
            case (kind)
                PIECE_LPAREN: send_byte(CHAR_LPAREN);
                PIECE_RPAREN: send_byte(CHAR_RPAREN);
                PIECE_STRING: begin
                    len = pick_length(0, 6);
                    send_byte(CHAR_QUOTE);
                    repeat (len) send_byte(pick_string_byte());
                    send_byte(CHAR_QUOTE);
                end
                PIECE_SYMBOL: begin
                    len = pick_length(1, 6);
                    send_byte(pick_symbol_byte(1'b1));
                    repeat (len - 1) send_byte(pick_symbol_byte(1'b0));
                end
                PIECE_BLANK: repeat ($urandom_range(1, 3)) send_byte(pick_blank());
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        // close the text, now and then inside an open string
        if ($urandom_range(0, 7) == 0) begin
            send_byte(CHAR_QUOTE);
            repeat ($urandom_range(0, 4)) send_byte(pick_string_byte());
        end
        send_byte(CHAR_NUL);
    endtask

    task automatic test_random_texts();
        int first;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES) send_random_text();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(0, 30);

        test_paren_string_symbol();
        test_symbol_endings();
        test_blanks_and_bad_strings();
        test_random_texts();
        test_random_texts();

        // drop valid, drain the token queue, allow for pipeline latency
        if (valid_held) i_valid <= 1'b0;
        valid_held = 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("sexpr_token_scanner_core: match");
        else
            $display("sexpr_token_scanner_core: mismatch");
        $finish;
    end

endmodule
